// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the cursor engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every clock edge out of reset
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tcce_pkg.sv =====
// types and constants of the text console cursor engine
`timescale 1ns / 1ps

package tcce_pkg;

    // control bytes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    // configuration register indexes
    localparam logic [2:0] REG_COLUMNS      = 3'd0;
    localparam logic [2:0] REG_ROWS         = 3'd1;
    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MARGIN_X     = 3'd4;
    localparam logic [2:0] REG_MARGIN_Y     = 3'd5;

    // reset values of the configuration registers
    localparam logic [9:0] RST_COLUMNS      = 10'd80;
    localparam logic [8:0] RST_ROWS         = 9'd30;
    localparam logic [5:0] RST_GLYPH_WIDTH  = 6'd8;
    localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;

    // grid and glyph limits
    localparam logic [9:0] MAX_COLUMNS = 10'd512;
    localparam logic [8:0] MAX_ROWS    = 9'd256;
    localparam logic [5:0] MAX_GLYPH   = 6'd32;

    localparam int CFG_DATA_W = 10;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // one result item
    typedef struct packed {
        logic        draw;
        logic [7:0]  glyph;
        logic [14:0] pixel_x;
        logic [12:0] pixel_y;
        logic        scroll;
        logic [8:0]  cursor_col;
        logic [7:0]  cursor_row;
    } t_result;

endpackage

// ===== rtl/core/text_console_cursor_engine.sv =====
// text console cursor engine: cursor tracking and glyph placement per byte
`timescale 1ns / 1ps
//
// channel   direction  handshake                       payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: char_code
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata, tuser: result item
// cfg       in         i_cfg_valid/o_cfg_ready         index, data
//
// one byte per cycle sustained; each byte is decoded, the cursor updated and the
// result registered in the cycle of its transfer
// the only stall is a result register held by the downstream side
// synchronous active-low reset returns cursor to (0,0) and registers to defaults
// configuration writes are always taken

module text_console_cursor_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] glyph, [22:8] pixel_x, [35:23] pixel_y, [44:36] cursor_col,
    // [52:45] cursor_row, [55:53] zero
    output logic [tcce_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [tcce_pkg::OUT_USER_W-1:0] o_m_axis_tuser, // [0] draw, [1] scroll
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [9:0] r_columns;
    logic [8:0] r_rows;
    logic [5:0] r_glyph_w;
    logic [5:0] r_glyph_h;
    logic [4:0] r_margin_x;
    logic [4:0] r_margin_y;

    // cursor state
    logic [8:0] r_col;
    logic [7:0] r_row;
    logic [8:0] n_col;
    logic [7:0] n_row;

    // result register
    tcce_pkg::t_result r_out;
    tcce_pkg::t_result n_out;
    logic              r_out_valid;

    logic       s_xfer;
    logic [9:0] ncols;
    logic [8:0] nrows;
    logic [5:0] gw;
    logic [5:0] gh;
    logic [14:0] prod_x;
    logic [12:0] prod_y;
    logic [9:0] step_col;
    logic [8:0] step_row;
    logic [9:0] wrap_col;
    logic [8:0] wrap_row;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= tcce_pkg::RST_COLUMNS;
            r_rows     <= tcce_pkg::RST_ROWS;
            r_glyph_w  <= tcce_pkg::RST_GLYPH_WIDTH;
            r_glyph_h  <= tcce_pkg::RST_GLYPH_HEIGHT;
            r_margin_x <= 5'd0;
            r_margin_y <= 5'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcce_pkg::REG_COLUMNS:      r_columns  <= i_cfg_data[9:0];
                tcce_pkg::REG_ROWS:         r_rows     <= i_cfg_data[8:0];
                tcce_pkg::REG_GLYPH_WIDTH:  r_glyph_w  <= i_cfg_data[5:0];
                tcce_pkg::REG_GLYPH_HEIGHT: r_glyph_h  <= i_cfg_data[5:0];
                tcce_pkg::REG_MARGIN_X:     r_margin_x <= i_cfg_data[4:0];
                tcce_pkg::REG_MARGIN_Y:     r_margin_y <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp configuration to the supported grid and glyph range
    always_comb begin
        if (r_columns == 10'd0)
            ncols = 10'd1;
        else if (r_columns > tcce_pkg::MAX_COLUMNS)
            ncols = tcce_pkg::MAX_COLUMNS;
        else
            ncols = r_columns;

        if (r_rows == 9'd0)
            nrows = 9'd1;
        else if (r_rows > tcce_pkg::MAX_ROWS)
            nrows = tcce_pkg::MAX_ROWS;
        else
            nrows = r_rows;

        gw = (r_glyph_w > tcce_pkg::MAX_GLYPH) ? tcce_pkg::MAX_GLYPH : r_glyph_w;
        gh = (r_glyph_h > tcce_pkg::MAX_GLYPH) ? tcce_pkg::MAX_GLYPH : r_glyph_h;
    end

    // pixel position of the pre-step cursor
    assign prod_x = {6'd0, r_col} * {9'd0, gw};
    assign prod_y = {5'd0, r_row} * {7'd0, gh};

    // byte decode and cursor step
    always_comb begin
        n_out    = '0;
        step_col = {1'b0, r_col};
        step_row = {1'b0, r_row};

        unique case (i_s_axis_tdata)
            tcce_pkg::CH_NEWLINE: begin
                step_col = 10'd0;
                step_row = {1'b0, r_row} + 9'd1;
            end
            tcce_pkg::CH_RETURN: begin
                step_col = 10'd0;
            end
            tcce_pkg::CH_BACKSPACE: begin
                if (r_col == 9'd0) begin
                    // wrap to the end of the previous row, no move at top-left
                    if (r_row != 8'd0) begin
                        step_col = ncols - 10'd1;
                        step_row = {1'b0, r_row} - 9'd1;
                    end
                end else begin
                    step_col = {1'b0, r_col} - 10'd1;
                end
            end
            default: begin
                n_out.draw    = 1'b1;
                n_out.glyph   = i_s_axis_tdata;
                n_out.pixel_x = prod_x + {10'd0, r_margin_x};
                n_out.pixel_y = prod_y + {8'd0, r_margin_y};
                step_col      = {1'b0, r_col} + 10'd1;
            end
        endcase

        // column wrap then row limit
        wrap_col = step_col;
        wrap_row = step_row;
        if (step_col >= ncols) begin
            wrap_col = 10'd0;
            wrap_row = step_row + 9'd1;
        end
        if (wrap_row >= nrows) begin
            n_out.scroll = 1'b1;
            wrap_row     = nrows - 9'd1;
        end

        n_col            = wrap_col[8:0];
        n_row            = wrap_row[7:0];
        n_out.cursor_col = n_col;
        n_out.cursor_row = n_row;
    end

    // cursor state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 9'd0;
            r_row       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.cursor_row, r_out.cursor_col,
                              r_out.pixel_y, r_out.pixel_x, r_out.glyph};
    assign o_m_axis_tuser  = {r_out.scroll, r_out.draw};

    // checks
`include "assert_macros.svh"

    `TCCE_ASSERT_IMP(a_cursor_matches, r_out_valid, (r_out.cursor_col == r_col) && (r_out.cursor_row == r_row), "result cursor differs from cursor state")
    `TCCE_ASSERT_IMP(a_ctrl_no_draw, r_out_valid && !r_out.draw, (r_out.glyph == 8'd0) && (r_out.pixel_x == 15'd0) && (r_out.pixel_y == 13'd0), "control byte result carries draw fields")
    `TCCE_ASSERT_NEXT(a_printable_draws, s_xfer && (i_s_axis_tdata != tcce_pkg::CH_NEWLINE) && (i_s_axis_tdata != tcce_pkg::CH_RETURN) && (i_s_axis_tdata != tcce_pkg::CH_BACKSPACE), r_out.draw && (r_out.glyph == $past(i_s_axis_tdata)), "printable byte did not draw")
    `TCCE_ASSERT_IMP(a_ready_when_empty, !r_out_valid, o_s_axis_tready, "input stalled with empty result register")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the text console cursor engine
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_CHARS   = 1000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [7:0]                      i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [tcce_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [tcce_pkg::OUT_USER_W-1:0] o_m_axis_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [2:0]                      i_cfg_index;
    logic [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // shadow registers and cursor of the predictor
    logic [9:0] shadow_columns;
    logic [8:0] shadow_rows;
    logic [5:0] shadow_glyph_w;
    logic [5:0] shadow_glyph_h;
    logic [4:0] shadow_margin_x;
    logic [4:0] shadow_margin_y;
    logic [8:0] cursor_col;
    logic [7:0] cursor_row;

    tcce_pkg::t_result pending_results[$];
    int                mismatch_count;
    int                chars_sent;
    int                idle_cycles;
    bit                no_idle;

    text_console_cursor_engine i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // cursor step: draw position from the pre-step cursor, then wrap and scroll
    function automatic tcce_pkg::t_result step_cursor(input logic [7:0] ch);
        int unsigned       ncols;
        int unsigned       nrows;
        int unsigned       gw;
        int unsigned       gh;
        int unsigned       c;
        int unsigned       r;
        int unsigned       px;
        int unsigned       py;
        tcce_pkg::t_result res;
        ncols = (shadow_columns == 0) ? 1
              : (shadow_columns > tcce_pkg::MAX_COLUMNS) ? tcce_pkg::MAX_COLUMNS : shadow_columns;
        nrows = (shadow_rows == 0) ? 1
              : (shadow_rows > tcce_pkg::MAX_ROWS) ? tcce_pkg::MAX_ROWS : shadow_rows;
        gw    = (shadow_glyph_w > tcce_pkg::MAX_GLYPH) ? tcce_pkg::MAX_GLYPH : shadow_glyph_w;
        gh    = (shadow_glyph_h > tcce_pkg::MAX_GLYPH) ? tcce_pkg::MAX_GLYPH : shadow_glyph_h;
        c     = cursor_col;
        r     = cursor_row;
        res   = '0;
        case (ch)
            tcce_pkg::CH_NEWLINE: begin
                c = 0;
                r = r + 1;
            end
            tcce_pkg::CH_RETURN: begin
                c = 0;
            end
            tcce_pkg::CH_BACKSPACE: begin
                if (c == 0) begin
                    // top-left corner stays put
                    if (r != 0) begin
                        c = ncols - 1;
                        r = r - 1;
                    end
                end else begin
                    c = c - 1;
                end
            end
            default: begin
                px          = c * gw + shadow_margin_x;
                py          = r * gh + shadow_margin_y;
                res.draw    = 1'b1;
                res.glyph   = ch;
                res.pixel_x = px[14:0];
                res.pixel_y = py[12:0];
                c           = c + 1;
            end
        endcase
        if (c >= ncols) begin
            c = 0;
            r = r + 1;
        end
        if (r >= nrows) begin
            res.scroll = 1'b1;
            r          = nrows - 1;
        end
        cursor_col     = c[8:0];
        cursor_row     = r[7:0];
        res.cursor_col = cursor_col;
        res.cursor_row = cursor_row;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // one character transfer, with a random gap first
    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(step_cursor(ch));
        chars_sent++;
    endtask

    // stop sending until every result is back and the pipeline is empty
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, only called while the engine is idle
    task automatic write_reg(input logic [2:0] idx,
                             input logic [tcce_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tcce_pkg::REG_COLUMNS:      shadow_columns  = value[9:0];
            tcce_pkg::REG_ROWS:         shadow_rows     = value[8:0];
            tcce_pkg::REG_GLYPH_WIDTH:  shadow_glyph_w  = value[5:0];
            tcce_pkg::REG_GLYPH_HEIGHT: shadow_glyph_h  = value[5:0];
            tcce_pkg::REG_MARGIN_X:     shadow_margin_x = value[4:0];
            tcce_pkg::REG_MARGIN_Y:     shadow_margin_y = value[4:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input int cols, input int rws, input int gw, input int gh,
                             input int mx, input int my);
        wait_drained();
        write_reg(tcce_pkg::REG_COLUMNS, cols[9:0]);
        write_reg(tcce_pkg::REG_ROWS, rws[9:0]);
        write_reg(tcce_pkg::REG_GLYPH_WIDTH, gw[9:0]);
        write_reg(tcce_pkg::REG_GLYPH_HEIGHT, gh[9:0]);
        write_reg(tcce_pkg::REG_MARGIN_X, mx[9:0]);
        write_reg(tcce_pkg::REG_MARGIN_Y, my[9:0]);
    endtask

    // control bytes on the reset-default grid
    task automatic test_control_bytes();
        send_char(8'h41);
        send_char(tcce_pkg::CH_BACKSPACE);
        send_char(tcce_pkg::CH_BACKSPACE);   // corner, no move
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_BACKSPACE);   // back to the end of the row above
        send_char(8'hFF);                    // drawn in the last column, then wraps
        send_char(tcce_pkg::CH_RETURN);
        send_char(8'h00);
    endtask

    // wrap past the last column and scroll past the last row
    task automatic test_wrap_scroll();
        write_all(2, 2, 1, 1, 31, 31);
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);
        send_char(8'h64);
        send_char(tcce_pkg::CH_NEWLINE);
    endtask

    // zero and oversized grid and glyph registers
    task automatic test_grid_limits();
        write_all(0, 0, 0, 0, 0, 0);
        send_char(8'h78);
        send_char(tcce_pkg::CH_BACKSPACE);
        write_all(1023, 1023, 63, 63, 31, 31);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_BACKSPACE);   // lands on the last of 512 columns
        send_char(8'h5A);                    // widest pixel_x
        write_all(512, 256, 0, 0, 17, 9);
        send_char(8'h7E);                    // zero glyph size, position is the margin
    endtask

    // cursor left outside a grid that a write made smaller
    task automatic test_shrunk_grid();
        write_all(512, 256, 32, 32, 3, 5);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_BACKSPACE);
        write_all(4, 2, 8, 16, 0, 0);
        send_char(8'h71);
        send_char(tcce_pkg::CH_BACKSPACE);
    endtask

    function automatic logic [7:0] random_char(input int newline_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < newline_pct)
            return tcce_pkg::CH_NEWLINE;
        else if (pick < newline_pct + 5)
            return tcce_pkg::CH_RETURN;
        else if (pick < newline_pct + 12)
            return tcce_pkg::CH_BACKSPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int random_count(input int limit, input int common);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 8);
            1:       return $urandom_range(0, 1023);
            2:       return $urandom_range(1, common);
            default: return limit;
        endcase
    endfunction

    // random phases of register settings and character bursts
    task automatic test_random();
        int phase;
        int burst;
        int nl_pct;
        int gw;
        int gh;
        phase = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if (phase == 0) begin
                // tall grid, mostly newlines, so the cursor moves down many rows
                write_all(512, 256, 32, 32, 31, 31);
                burst  = 300;
                nl_pct = 55;
            end else if ($urandom_range(0, 5) == 0) begin
                // pause only, settings kept
                wait_drained();
                burst  = $urandom_range(10, 60);
                nl_pct = $urandom_range(0, 20);
            end else begin
                gw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
                gh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
                gw = gw | ($urandom_range(0, 15) << 6);
                gh = gh | ($urandom_range(0, 15) << 6);
                write_all(random_count(512, 80), random_count(256, 30), gw, gh,
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
                burst  = $urandom_range(10, 60);
                nl_pct = $urandom_range(0, 20);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (burst) send_char(random_char(nl_pct));
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // stimulus and final verdict
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = tcce_pkg::REG_COLUMNS;
        i_cfg_data      = '0;
        no_idle         = 1'b0;
        mismatch_count  = 0;
        chars_sent      = 0;
        shadow_columns  = tcce_pkg::RST_COLUMNS;
        shadow_rows     = tcce_pkg::RST_ROWS;
        shadow_glyph_w  = tcce_pkg::RST_GLYPH_WIDTH;
        shadow_glyph_h  = tcce_pkg::RST_GLYPH_HEIGHT;
        shadow_margin_x = '0;
        shadow_margin_y = '0;
        cursor_col      = '0;
        cursor_row      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_control_bytes();
        test_wrap_scroll();
        test_grid_limits();
        test_shrunk_grid();
        chars_sent = 0;
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                i_m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        tcce_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser[0] !== want.draw)
                    report_mismatch("draw", o_m_axis_tuser[0], want.draw);
                if (o_m_axis_tdata[7:0] !== want.glyph)
                    report_mismatch("glyph", o_m_axis_tdata[7:0], want.glyph);
                if (o_m_axis_tdata[22:8] !== want.pixel_x)
                    report_mismatch("pixel_x", o_m_axis_tdata[22:8], want.pixel_x);
                if (o_m_axis_tdata[35:23] !== want.pixel_y)
                    report_mismatch("pixel_y", o_m_axis_tdata[35:23], want.pixel_y);
                if (o_m_axis_tuser[1] !== want.scroll)
                    report_mismatch("scroll", o_m_axis_tuser[1], want.scroll);
                if (o_m_axis_tdata[44:36] !== want.cursor_col)
                    report_mismatch("cursor_col", o_m_axis_tdata[44:36], want.cursor_col);
                if (o_m_axis_tdata[52:45] !== want.cursor_row)
                    report_mismatch("cursor_row", o_m_axis_tdata[52:45], want.cursor_row);
                if (o_m_axis_tdata[55:53] !== 3'd0)
                    report_mismatch("tdata pad", o_m_axis_tdata[55:53], 0);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
